FILE: design/assert_macros.svh
// Assertion macros shared by the shooter control checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/shmjr_pkg.sv
// Package for the shooter mode and jam reversal block: types, widths, codes.
`timescale 1ns / 1ps

package shmjr_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRICTION_REF = 3'd0,
        CFG_FIRE_FEED    = 3'd1,
        CFG_STALL_SPEED  = 3'd2,
        CFG_STALL_TICKS  = 3'd3,
        CFG_REV_TICKS    = 3'd4,
        CFG_REV_FEED     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        LEVER_UP   = 2'd0,
        LEVER_MID  = 2'd1,
        LEVER_DOWN = 2'd2,
        LEVER_BAD  = 2'd3
    } t_lever;

endpackage

FILE: design/shooter_mode_and_jam_reversal.sv
// Top level: shooter mode selection, friction latch and feeder jam reversal.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  s_axis_tdata[31:0] tick inputs
//  m_axis    out  m_axis_tvalid / m_axis_tready  m_axis_tdata[55:0] motor refs
//  cfg       in   i_cfg_wr_en                    i_cfg_index, i_cfg_wr_data
//
//  One beat per cycle unless stalled; one output register holds the result
//  in the cycle after the beat. State (latch, jam counter) updates on accept.
//  Input is taken while the output register is empty or being drained.
//  Synchronous active-low reset clears state, config and the output valid.
`timescale 1ns / 1ps

module shooter_mode_and_jam_reversal (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] right_switch, [3:2] left_switch, [4] link_lost, [5] arm_key_now,
    // [6] arm_key_before, [7] disarm_key_now, [8] disarm_key_before,
    // [9] trigger_held, [25:10] feeder_rpm, [31:26] zero
    input  logic [shmjr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] motors_off, [16:1] left_friction_ref, [31:17] right_friction_ref,
    // [47:32] feeder_ref, [48] jam_reversing, [49] friction_armed, [55:50] zero
    output logic [shmjr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [shmjr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [shmjr_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data
);
    import shmjr_pkg::*;

    // config
    logic [14:0] r_frc_rpm;
    logic [15:0] r_fire_feed;
    logic [14:0] r_stall_spd;
    logic [14:0] r_stall_ticks;
    logic [14:0] r_rev_ticks;
    logic [15:0] r_rev_feed;

    // state
    logic        r_latch, n_latch;
    logic [15:0] r_jam_cnt, n_jam_cnt;

    // result register
    logic        r_out_valid;
    logic        r_off, n_off;
    logic [15:0] r_left, n_left;
    logic [14:0] r_right, n_right;
    logic [15:0] r_feed, n_feed;
    logic        r_rev, n_rev;

    // unpacked input beat
    t_lever      w_rsw, w_lsw;
    logic        w_lost, w_arm_now, w_arm_bef, w_dis_now, w_dis_bef, w_trig;
    logic [15:0] w_meas;
    logic        w_accept;

    assign w_rsw     = t_lever'(s_axis_tdata[1:0]);
    assign w_lsw     = t_lever'(s_axis_tdata[3:2]);
    assign w_lost    = s_axis_tdata[4];
    assign w_arm_now = s_axis_tdata[5];
    assign w_arm_bef = s_axis_tdata[6];
    assign w_dis_now = s_axis_tdata[7];
    assign w_dis_bef = s_axis_tdata[8];
    assign w_trig    = s_axis_tdata[9];
    assign w_meas    = s_axis_tdata[25:10];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frc_rpm     <= '0;
            r_fire_feed   <= '0;
            r_stall_spd   <= '0;
            r_stall_ticks <= '0;
            r_rev_ticks   <= '0;
            r_rev_feed    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRICTION_REF: r_frc_rpm     <= i_cfg_wr_data[14:0];
                CFG_FIRE_FEED:    r_fire_feed   <= i_cfg_wr_data;
                CFG_STALL_SPEED:  r_stall_spd   <= i_cfg_wr_data[14:0];
                CFG_STALL_TICKS:  r_stall_ticks <= i_cfg_wr_data[14:0];
                CFG_REV_TICKS:    r_rev_ticks   <= i_cfg_wr_data[14:0];
                CFG_REV_FEED:     r_rev_feed    <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic        drive;
        logic [15:0] req;
        logic [15:0] mag;
        logic        stalled;
        logic [15:0] cnt;
        logic [15:0] stl;

        drive   = 1'b0;
        req     = '0;
        n_latch = r_latch;
        stl     = {1'b0, r_stall_ticks};

        priority if (w_rsw == LEVER_DOWN || w_lost) begin
            n_latch = 1'b0;
        end else if (w_rsw == LEVER_MID) begin
            if (w_lsw == LEVER_MID) begin
                drive = 1'b1;
            end else if (w_lsw == LEVER_UP) begin
                drive = 1'b1;
                req   = r_fire_feed;
            end
        end else if (w_rsw == LEVER_UP) begin
            if (w_arm_now && !w_arm_bef) begin
                n_latch = 1'b1;
            end else if (w_dis_now && !w_dis_bef) begin
                n_latch = 1'b0;
            end
            if (n_latch) begin
                drive = 1'b1;
                req   = w_trig ? r_fire_feed : 16'd0;
            end
        end else begin
            n_latch = r_latch;
        end

        mag     = w_meas[15] ? 16'(16'd0 - w_meas) : w_meas;
        stalled = (mag < {1'b0, r_stall_spd})
               && ($signed(req) > $signed({1'b0, r_stall_spd}));

        cnt = r_jam_cnt;
        if (stalled) begin
            if (r_jam_cnt < stl) begin
                cnt = r_jam_cnt + 16'd1;
            end else if (r_jam_cnt == stl) begin
                cnt = r_jam_cnt + {1'b0, r_rev_ticks};
            end
        end else if (r_jam_cnt <= stl) begin
            cnt = '0;
        end

        n_off     = !drive;
        n_left    = '0;
        n_right   = '0;
        n_feed    = '0;
        n_rev     = 1'b0;
        n_jam_cnt = r_jam_cnt;
        if (drive) begin
            n_left    = 16'(16'd0 - {1'b0, r_frc_rpm});
            n_right   = r_frc_rpm;
            n_feed    = req;
            n_jam_cnt = cnt;
            if (cnt > stl) begin
                n_feed    = r_rev_feed;
                n_jam_cnt = cnt - 16'd1;
                n_rev     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch     <= 1'b0;
            r_jam_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_latch   <= n_latch;
                r_jam_cnt <= n_jam_cnt;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_off   <= n_off;
            r_left  <= n_left;
            r_right <= n_right;
            r_feed  <= n_feed;
            r_rev   <= n_rev;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_latch, r_rev, r_feed, r_right, r_left, r_off};

endmodule

FILE: design/shmjr_checker.sv
// Port-level checker for the shooter control block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shmjr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [shmjr_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import shmjr_pkg::*;

    logic        w_off;
    logic [15:0] w_left;
    logic [14:0] w_right;
    logic [16:0] w_rest;

    assign w_off   = m_axis_tdata[0];
    assign w_left  = m_axis_tdata[16:1];
    assign w_right = m_axis_tdata[31:17];
    assign w_rest  = m_axis_tdata[48:32];

    `ASSERT_CLK_NR(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")
    `ASSERT_CLK(a_off_zero, i_clk, i_rst_n, m_axis_tvalid && w_off |-> w_left == 16'd0 && w_right == 15'd0 && w_rest == 17'd0, "nonzero refs while off")
    `ASSERT_CLK(a_frc_sym, i_clk, i_rst_n, m_axis_tvalid && !w_off |-> 16'(w_left + {1'b0, w_right}) == 16'd0, "friction refs not opposite")

endmodule

bind shooter_mode_and_jam_reversal shmjr_checker u_shmjr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
